// ===== sv/rcs_pkg.sv =====
// shared types and constants for the content-defined chunker with sketch
package rcs_pkg;

    localparam int LEN_W    = 21;
    localparam int MASK_W   = 12;
    localparam int HASH_W   = 64;
    localparam int EPOCH_W  = 32;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_DEPTH = 4;
    localparam int MID_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BLOCK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BLOCK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_MASK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BREAK_PAT = 3'd3;

    localparam logic [LEN_W-1:0]  RST_MIN_BLOCK = 21'd4096;
    localparam logic [LEN_W-1:0]  RST_MAX_BLOCK = 21'd131072;
    localparam logic [MASK_W-1:0] RST_HASH_MASK = 12'd4095;
    localparam logic [MASK_W-1:0] RST_BREAK_PAT = 12'd2;

    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [MASK_W-1:0] masked;
        logic              start;
        logic              seg_end;
        logic              blk_end;
        logic              trailing;
        logic [LEN_W-1:0]  length;
    } t_work;

    typedef struct packed {
        logic [LEN_W-1:0]  length;
        logic [HASH_W-1:0] sketch;
        logic              trailing;
    } t_result;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [HASH_W-1:0]  sum;
    } t_bin_entry;

    localparam int WORK_W   = $bits(t_work);
    localparam int RESULT_W = $bits(t_result);

endpackage

// ===== sv/rcs_fifo.sv =====
// small register queue used between front and back and on the result side
module rcs_fifo
    import rcs_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    output logic                       o_full,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== sv/rcs_front.sv =====
// front: rolling hash, length and segment counting, boundary classification
module rcs_front
    import rcs_pkg::*;
#(
    parameter int WINDOW_BYTES  = 32,
    parameter int SEGMENT_BYTES = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LEN_W-1:0]     i_cfg_wdata,
    input  logic                 i_accept,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_chunk_start,
    input  logic                 i_chunk_end,
    output t_work                o_work
);
    localparam int SW = $clog2(WINDOW_BYTES);
    localparam int GW = $clog2(SEGMENT_BYTES);

    logic [LEN_W-1:0]  r_min, r_max;
    logic [MASK_W-1:0] r_mask, r_pat;
    logic [7:0]        r_win [WINDOW_BYTES];
    logic [SW-1:0]     r_slot, n_slot;
    logic [HASH_W-1:0] r_hash;
    logic [LEN_W-1:0]  r_blk, n_blk;
    logic [GW-1:0]     r_seg, n_seg;

    logic [HASH_W-1:0] hash_base, hash;
    logic [LEN_W-1:0]  blk_base, blk;
    logic [GW-1:0]     seg_base;
    logic [7:0]        leaving;
    logic [MASK_W-1:0] masked;
    logic              seg_end, boundary, emit;

    always_comb begin
        hash_base = i_chunk_start ? '0 : r_hash;
        blk_base  = i_chunk_start ? '0 : r_blk;
        seg_base  = i_chunk_start ? '0 : r_seg;
        leaving   = r_win[r_slot];
        hash      = (hash_base << 1) + HASH_W'(i_data_byte)
                  - (HASH_W'(leaving) << WINDOW_BYTES);
        masked    = hash[MASK_W-1:0] & r_mask;
        blk       = blk_base + 1'b1;
        seg_end   = (seg_base == GW'(SEGMENT_BYTES-1));
        boundary  = (blk >= r_min) && ((masked == r_pat) || (blk >= r_max));
        emit      = boundary || i_chunk_end;
        n_slot    = (r_slot == SW'(WINDOW_BYTES-1)) ? '0 : r_slot + 1'b1;
        n_seg     = (seg_end || emit) ? '0 : seg_base + 1'b1;
        n_blk     = emit ? '0 : blk;

        o_work.hash     = hash;
        o_work.masked   = masked;
        o_work.start    = i_chunk_start;
        o_work.seg_end  = seg_end;
        o_work.blk_end  = emit;
        o_work.trailing = !boundary;
        o_work.length   = blk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min  <= RST_MIN_BLOCK;
            r_max  <= RST_MAX_BLOCK;
            r_mask <= RST_HASH_MASK;
            r_pat  <= RST_BREAK_PAT;
            r_slot <= '0;
            r_hash <= '0;
            r_blk  <= '0;
            r_seg  <= '0;
            for (int i = 0; i < WINDOW_BYTES; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MIN_BLOCK: r_min  <= i_cfg_wdata;
                    CFG_MAX_BLOCK: r_max  <= i_cfg_wdata;
                    CFG_HASH_MASK: r_mask <= i_cfg_wdata[MASK_W-1:0];
                    CFG_BREAK_PAT: r_pat  <= i_cfg_wdata[MASK_W-1:0];
                    default: ;
                endcase
            end
            if (i_accept) begin
                r_win[r_slot] <= i_data_byte;
                r_slot        <= n_slot;
                r_hash        <= hash;
                r_blk         <= n_blk;
                r_seg         <= n_seg;
            end
        end
    end

endmodule

// ===== sv/rcs_back.sv =====
// back: bin read-modify-write with epoch tags, fullest bin and sketch
module rcs_back
    import rcs_pkg::*;
#(
    parameter int SKETCH_BINS = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  t_work                        i_work,
    output logic                         o_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] i_out_count,
    output logic                         o_res_push,
    output t_result                      o_result,
    output logic                         o_init_done
);
    localparam int BW = $clog2(SKETCH_BINS);
    localparam int CW = $clog2(OUT_DEPTH+1);

    t_bin_entry        r_mem [SKETCH_BINS];
    t_bin_entry        r_rd;
    logic              r_init_done;
    logic [BW-1:0]     r_sweep;

    logic              r_b1_valid;
    t_work             r_b1;
    logic [BW-1:0]     r_b1_bin;

    logic [EPOCH_W-1:0] r_epoch, n_epoch, eff_epoch;
    logic [BW-1:0]     r_full_bin, n_full_bin, full_bin_cur;
    logic [HASH_W-1:0] r_full_sum, n_full_sum, full_sum_cur;
    logic [HASH_W-1:0] r_sketch, n_sketch, sketch_cur, sketch_out;

    logic              r_fwd_valid;
    logic [BW-1:0]     r_fwd_bin;
    logic [HASH_W-1:0] r_fwd_sum;
    logic [EPOCH_W-1:0] r_fwd_epoch;

    logic [HASH_W-1:0] old_sum, new_sum;
    logic [CW:0]       occupancy;
    logic              wr_en;
    logic [BW-1:0]     wr_addr;
    t_bin_entry        wr_entry;

    assign occupancy   = {1'b0, i_out_count} + (CW+1)'(r_b1_valid);
    assign o_pop       = i_valid && r_init_done && (occupancy < (CW+1)'(OUT_DEPTH));
    assign o_init_done = r_init_done;

    always_comb begin
        eff_epoch    = r_epoch + EPOCH_W'(r_b1.start);
        full_bin_cur = r_b1.start ? '0 : r_full_bin;
        full_sum_cur = r_b1.start ? '0 : r_full_sum;
        sketch_cur   = r_b1.start ? '0 : r_sketch;
        if (r_b1.start) begin
            old_sum = '0;
        end else if (r_fwd_valid && r_fwd_bin == r_b1_bin && r_fwd_epoch == eff_epoch) begin
            old_sum = r_fwd_sum;
        end else if (r_rd.epoch == eff_epoch) begin
            old_sum = r_rd.sum;
        end else begin
            old_sum = '0;
        end
        new_sum = old_sum + r_b1.hash;

        n_full_bin = full_bin_cur;
        n_full_sum = full_sum_cur;
        if (r_b1_bin == full_bin_cur) begin
            n_full_sum = new_sum;
        end else if (new_sum > full_sum_cur) begin
            n_full_bin = r_b1_bin;
            n_full_sum = new_sum;
        end
        sketch_out = sketch_cur + (r_b1.seg_end ? n_full_sum : '0);
        n_sketch   = r_b1.blk_end ? '0 : sketch_out;
        if (r_b1.seg_end || r_b1.blk_end) begin
            n_full_bin = '0;
            n_full_sum = '0;
        end
        n_epoch = eff_epoch + EPOCH_W'(r_b1.seg_end || r_b1.blk_end);

        o_res_push        = r_b1_valid && r_b1.blk_end;
        o_result.length   = r_b1.length;
        o_result.sketch   = sketch_out;
        o_result.trailing = r_b1.trailing;

        wr_en          = !r_init_done || r_b1_valid;
        wr_addr        = r_init_done ? r_b1_bin : r_sweep;
        wr_entry.epoch = r_init_done ? eff_epoch : '0;
        wr_entry.sum   = r_init_done ? new_sum : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_done <= 1'b0;
            r_sweep     <= '0;
            r_b1_valid  <= 1'b0;
            r_epoch     <= '0;
            r_full_bin  <= '0;
            r_full_sum  <= '0;
            r_sketch    <= '0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (!r_init_done) begin
                r_sweep <= r_sweep + 1'b1;
                if (r_sweep == BW'(SKETCH_BINS-1)) begin
                    r_init_done <= 1'b1;
                end
            end
            r_b1_valid <= o_pop;
            if (r_b1_valid) begin
                r_epoch     <= n_epoch;
                r_full_bin  <= n_full_bin;
                r_full_sum  <= n_full_sum;
                r_sketch    <= n_sketch;
                r_fwd_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b1     <= i_work;
            r_b1_bin <= BW'(i_work.masked);
            r_rd     <= r_mem[BW'(i_work.masked)];
        end
        if (r_b1_valid) begin
            r_fwd_bin   <= r_b1_bin;
            r_fwd_sum   <= new_sum;
            r_fwd_epoch <= eff_epoch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_entry;
        end
    end

endmodule

// ===== sv/rabin_chunker_with_sketch.sv =====
// top level: content-defined chunker with per-block similarity sketch
// a result goes through the mid queue, the back stage and then the result queue
// throughput: one byte per cycle unless full; one bin read-modify-write per byte
// reset: synchronous active-low; registers return to their reset values
// after reset a clearing pass runs over every entry of the bin memory,
// full stays high until it ends; configuration writes are taken throughout
module rabin_chunker_with_sketch
    import rcs_pkg::*;
#(
    parameter int WINDOW_BYTES  = 32,
    parameter int SKETCH_BINS   = 4096,
    parameter int SEGMENT_BYTES = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LEN_W-1:0]     i_cfg_wdata,
    input  logic                 push,
    output logic                 full,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_chunk_start,
    input  logic                 i_chunk_end,
    output logic                 empty,
    input  logic                 pop,
    output logic [LEN_W-1:0]     o_block_length,
    output logic [HASH_W-1:0]    o_block_sketch,
    output logic                 o_trailing_block
);
    t_work                            front_work, mid_work;
    t_result                          back_result, out_result;
    logic                             accept, mid_full, mid_empty, mid_pop;
    logic                             res_push, out_full, init_done;
    logic [$clog2(MID_DEPTH+1)-1:0]   mid_count;
    logic [$clog2(OUT_DEPTH+1)-1:0]   out_count;
    logic [WORK_W-1:0]                mid_data;
    logic [RESULT_W-1:0]              out_data;

    assign full   = mid_full || !init_done;
    assign accept = push && !full;

    rcs_front #(
        .WINDOW_BYTES  (WINDOW_BYTES),
        .SEGMENT_BYTES (SEGMENT_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_accept      (accept),
        .i_data_byte   (i_data_byte),
        .i_chunk_start (i_chunk_start),
        .i_chunk_end   (i_chunk_end),
        .o_work        (front_work)
    );

    rcs_fifo #(
        .WIDTH (WORK_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_work),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_data  (mid_data),
        .o_empty (mid_empty),
        .o_count (mid_count)
    );

    assign mid_work = t_work'(mid_data);

    rcs_back #(
        .SKETCH_BINS (SKETCH_BINS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (!mid_empty),
        .i_work      (mid_work),
        .o_pop       (mid_pop),
        .i_out_count (out_count),
        .o_res_push  (res_push),
        .o_result    (back_result),
        .o_init_done (init_done)
    );

    rcs_fifo #(
        .WIDTH (RESULT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_result),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_data),
        .o_empty (empty),
        .o_count (out_count)
    );

    assign out_result       = t_result'(out_data);
    assign o_block_length   = out_result.length;
    assign o_block_sketch   = out_result.sketch;
    assign o_trailing_block = out_result.trailing;

    a_no_result_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(res_push && out_full))
        else $error("result transfer into a full result queue");

    a_no_result_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !init_done |-> (empty && mid_count == '0))
        else $error("work present during bin clearing pass");

    a_no_pop_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !init_done |-> !mid_pop)
        else $error("bin update during clearing pass");

endmodule

// ===== dv/rabin_chunker_with_sketch_tb.sv =====
// testbench for the content-defined chunker with per-block similarity sketch
`timescale 1ns / 1ps

module rabin_chunker_with_sketch_tb;
    import rcs_pkg::*;

    localparam int WIN       = 32;
    localparam int BINS      = 4096;
    localparam int SEG       = 1024;
    localparam int LIMIT     = 600000;
    localparam int DRAIN_CYC = 8;

    typedef struct {
        bit [7:0] data;
        bit       first;
        bit       last;
    } byte_item_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_MIN_BLOCK;
    logic [LEN_W-1:0]     i_cfg_wdata = '0;
    logic                 push = 1'b0;
    logic                 full;
    logic [7:0]           i_data_byte = '0;
    logic                 i_chunk_start = 1'b0;
    logic                 i_chunk_end = 1'b0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [LEN_W-1:0]     o_block_length;
    logic [HASH_W-1:0]    o_block_sketch;
    logic                 o_trailing_block;

    rabin_chunker_with_sketch i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_wdata(i_cfg_wdata),
        .push(push), .full(full),
        .i_data_byte(i_data_byte), .i_chunk_start(i_chunk_start), .i_chunk_end(i_chunk_end),
        .empty(empty), .pop(pop),
        .o_block_length(o_block_length), .o_block_sketch(o_block_sketch),
        .o_trailing_block(o_trailing_block)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // chunker state mirror
    logic [LEN_W-1:0]  min_len = RST_MIN_BLOCK;
    logic [LEN_W-1:0]  max_len = RST_MAX_BLOCK;
    logic [MASK_W-1:0] hmask   = RST_HASH_MASK;
    logic [MASK_W-1:0] brk_pat = RST_BREAK_PAT;
    logic [7:0]        win_byte[WIN];
    logic [4:0]        win_slot = '0;
    logic [63:0]       hash = '0;
    logic [LEN_W-1:0]  blk_len = '0;
    int unsigned       seg_cnt = 0;
    logic [63:0]       bin_sum[BINS];
    logic [11:0]       fullest = '0;
    logic [63:0]       sketch = '0;

    byte_item_t  pend_q[$];
    t_result     blocks_q[$];
    int          err_cnt = 0;
    int          snd_gap = 0;
    int          rcv_hold = 0;
    bit          snd_fast = 1'b0;
    bit          rcv_fast = 1'b0;
    int          stall_req = 0;
    int          stall_done = 0;
    byte_item_t  cur;

    initial begin
        foreach (win_byte[k]) win_byte[k] = '0;
        foreach (bin_sum[k]) bin_sum[k] = '0;
    end

    function automatic void clear_block();
        foreach (bin_sum[k]) bin_sum[k] = '0;
        fullest = '0;
        seg_cnt = 0;
        sketch  = '0;
        blk_len = '0;
    endfunction

    function automatic void chunk_step(byte_item_t it);
        logic [63:0] leaving;
        logic [11:0] masked;
        t_result     r;
        if (it.first) begin
            hash = '0;
            clear_block();
        end
        leaving = {56'd0, win_byte[win_slot]};
        win_byte[win_slot] = it.data;
        hash = (hash << 1) + {56'd0, it.data};
        hash = hash - (leaving << WIN);
        win_slot = win_slot + 5'd1;
        masked = hash[11:0] & hmask;
        bin_sum[masked] = bin_sum[masked] + hash;
        if (bin_sum[masked] > bin_sum[fullest]) fullest = masked;
        seg_cnt++;
        if (seg_cnt >= SEG) begin
            sketch = sketch + bin_sum[fullest];
            foreach (bin_sum[k]) bin_sum[k] = '0;
            fullest = '0;
            seg_cnt = 0;
        end
        blk_len = blk_len + 1'b1;
        if (blk_len >= min_len && (masked == brk_pat || blk_len >= max_len)) begin
            r.length = blk_len; r.sketch = sketch; r.trailing = 1'b0;
            blocks_q.push_back(r);
            clear_block();
        end else if (it.last) begin
            r.length = blk_len; r.sketch = sketch; r.trailing = 1'b1;
            blocks_q.push_back(r);
            clear_block();
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        bit acc;
        bit nxt;
        acc = push && !full;
        nxt = 1'b0;
        if (!i_rst_n) begin
            nxt = 1'b0;
        end else begin
            if (acc) begin
                chunk_step(cur);
                snd_gap = snd_fast ? 0 : $urandom_range(0, 6);
            end
            if (push && !acc) begin
                nxt = 1'b1;
            end else if (snd_gap > 0) begin
                snd_gap--;
            end else if (pend_q.size() > 0) begin
                cur = pend_q.pop_front();
                i_data_byte   <= cur.data;
                i_chunk_start <= cur.first;
                i_chunk_end   <= cur.last;
                nxt = 1'b1;
            end
        end
        push <= nxt;
    end

    // monitor
    always @(posedge i_clk) begin
        t_result e;
        bit nxt;
        nxt = 1'b0;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (blocks_q.size() == 0) begin
                    $error("unexpected block: length %0d", o_block_length);
                    err_cnt++;
                end else begin
                    e = blocks_q.pop_front();
                    if (o_block_length !== e.length) begin
                        $error("block_length exp %0d got %0d", e.length, o_block_length);
                        err_cnt++;
                    end
                    if (o_block_sketch !== e.sketch) begin
                        $error("block_sketch exp %h got %h", e.sketch, o_block_sketch);
                        err_cnt++;
                    end
                    if (o_trailing_block !== e.trailing) begin
                        $error("trailing_block exp %0b got %0b", e.trailing,
                               o_trailing_block);
                        err_cnt++;
                    end
                end
                rcv_hold = rcv_fast ? 0 : $urandom_range(0, 6);
            end
            if (stall_done != stall_req) begin
                stall_done = stall_req;
                rcv_hold = 400;
            end
            if (rcv_hold > 0) rcv_hold--;
            else nxt = 1'b1;
        end
        pop <= nxt;
    end

    // watchdog
    always @(posedge i_clk) begin
        int cyc;
        cyc++;
        if (cyc > LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val[LEN_W-1:0];
        @(posedge i_clk);
        case (idx)
            CFG_MIN_BLOCK: min_len = val[LEN_W-1:0];
            CFG_MAX_BLOCK: max_len = val[LEN_W-1:0];
            CFG_HASH_MASK: hmask   = val[MASK_W-1:0];
            CFG_BREAK_PAT: brk_pat = val[MASK_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_cfg(int unsigned mn, int unsigned mx, int unsigned mk, int unsigned pt);
        cfg_write(CFG_MIN_BLOCK, mn);
        cfg_write(CFG_MAX_BLOCK, mx);
        cfg_write(CFG_HASH_MASK, mk);
        cfg_write(CFG_BREAK_PAT, pt);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_item(bit [7:0] d, bit s, bit e);
        byte_item_t it;
        it.data = d; it.first = s; it.last = e;
        pend_q.push_back(it);
    endtask

    task automatic add_chunk(int len);
        bit [7:0] d;
        for (int k = 0; k < len; k++) begin
            d = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
            add_item(d, k == 0, k == len - 1);
        end
    endtask

    task automatic add_random(int n, int maxlen);
        int cnt;
        int len;
        cnt = 0;
        while (cnt < n) begin
            if ($urandom_range(0, 9) == 0) begin
                add_item(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
                cnt++;
            end else begin
                len = $urandom_range(1, maxlen);
                add_chunk(len);
                cnt += len;
            end
        end
    endtask

    task automatic drain();
        while (pend_q.size() != 0 || push || blocks_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        snd_fast = $urandom_range(0, 2) == 0;
        rcv_fast = $urandom_range(0, 2) == 0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: only chunk ends can close a block
        add_item(8'h00, 1'b1, 1'b0);
        add_item(8'hff, 1'b0, 1'b0);
        add_item(8'hff, 1'b0, 1'b1);
        add_item(8'h80, 1'b1, 1'b1);
        add_item(8'h01, 1'b0, 1'b1);
        add_item(8'h7f, 1'b0, 1'b0);
        add_item(8'h00, 1'b0, 1'b1);
        drain();

        // tiny blocks, boundary on the last byte of a chunk
        set_cfg(1, 1048576, 4095, 4095);
        add_item(8'hff, 1'b1, 1'b0);
        add_item(8'h00, 1'b0, 1'b1);
        drain();
        set_cfg(1, 3, 0, 0);
        for (int k = 0; k < 6; k++) add_item(8'($urandom), k == 0, k == 5);
        add_item(8'haa, 1'b1, 1'b1);
        drain();

        // every byte closes a block; receiver stalls long so input backs up
        set_cfg(0, 0, 0, 0);
        stall_req++;
        add_random(40, 12);
        drain();

        set_cfg(1, 1048576, 3, $urandom_range(0, 3));
        add_random(30, 20);
        drain();

        set_cfg(16, 64, 15, 15);
        add_random(40, 40);
        drain();

        // min above max
        set_cfg(40, 20, 4095, $urandom_range(0, 4095));
        add_random(20, 30);
        drain();

        set_cfg(1048576, 1, 4095, 2);
        add_random(15, 10);
        drain();

        // long block spanning a full segment, then a short trailing block
        set_cfg(1026, 1026, 4095, 4095);
        add_chunk(1030);
        drain();

        if (err_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
